// ----- rtl/bms_pkg.sv -----
`default_nettype none

package bms_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STOP_CHARGE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_CHARGE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_OFF    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_LOW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAINS_RETURN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_GAP       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_LOAD    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_DISABL = 3'd7;

    localparam logic [15:0] RST_STOP_CHARGE  = 16'd4150;
    localparam logic [15:0] RST_START_CHARGE = 16'd3900;
    localparam logic [15:0] RST_BATTERY_OFF  = 16'd3300;
    localparam logic [15:0] RST_BATTERY_LOW  = 16'd3600;
    localparam logic [15:0] RST_MAINS_RETURN = 16'd10000;
    localparam logic [11:0] RST_BAND_GAP     = 12'd200;
    localparam logic [15:0] RST_SETTLE_LOAD  = 16'd2000;

    localparam logic [2:0] LVL_NONE     = 3'd0;
    localparam logic [2:0] LVL_GOOD     = 3'd1;
    localparam logic [2:0] LVL_LOW      = 3'd2;
    localparam logic [2:0] LVL_CRITICAL = 3'd3;
    localparam logic [2:0] LVL_MAINS    = 3'd4;

    localparam logic [1:0] NOTIFY_NONE      = 2'd0;
    localparam logic [1:0] NOTIFY_STATUS    = 2'd1;
    localparam logic [1:0] NOTIFY_EMERGENCY = 2'd2;

    localparam logic [2:0] BEEP_KEEP  = 3'd0;
    localparam logic [2:0] BEEP_OFF   = 3'd1;
    localparam logic [2:0] BEEP_LONG  = 3'd2;
    localparam logic [2:0] BEEP_SHORT = 3'd3;
    localparam logic [2:0] BEEP_EXTRA = 3'd4;

    localparam logic [1:0] SHUT_KEEP   = 2'd0;
    localparam logic [1:0] SHUT_CANCEL = 2'd1;
    localparam logic [1:0] SHUT_ARM    = 2'd2;

    typedef struct packed {
        logic [15:0] vin_mv;
        logic [15:0] vbat_mv;
        logic        on_mains;
        logic        settle_tick;
    } in_word_t;

    typedef struct packed {
        logic       battery_enable;
        logic       charger_on;
        logic       battery_led;
        logic [2:0] battery_level;
        logic [1:0] notify_code;
        logic [2:0] beep_select;
        logic [1:0] shutdown_action;
        logic       switch_pulse;
    } out_word_t;

    typedef struct packed {
        logic [15:0] stop_charge_mv;
        logic [15:0] start_charge_mv;
        logic [15:0] battery_off_mv;
        logic [15:0] battery_low_mv;
        logic [15:0] mains_return_mv;
        logic [11:0] band_gap_mv;
        logic [15:0] settle_load;
        logic        battery_disabled;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  level_now;
        logic [2:0]  level_before;
        logic        charging;
        logic [15:0] settle_count;
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/battery_mains_supervisor.sv -----
// Battery/mains supervisor. Each input word is one measurement (mains and
// battery voltage, on-mains flag, settle tick); each produces exactly one
// result word with the enables, battery level, notification, beep choice,
// shutdown action and switch-back request. One word is accepted per cycle
// unless the block stalls: the word is captured in an input register,
// evaluated by a single pass of compare logic against the supervisor state,
// and the result lands in an output register once that register is free,
// which sets m_valid. New words are blocked only while the input register
// holds a word and a result waits with m_ready low.
// Configuration registers are written through cfg_valid/cfg_ready with a
// 3-bit index, always ready, and must only be written while the block is idle.
`default_nettype none

module battery_mains_supervisor (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  var bms_pkg::in_word_t          s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output bms_pkg::out_word_t             m_data,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [bms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire [bms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bms_pkg::*;

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    in_word_t  in_data_reg;
    logic      in_valid_reg;
    out_word_t result_next;
    out_word_t out_data_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      advance;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    bms_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .word       (in_data_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stop_charge_mv   <= RST_STOP_CHARGE;
            cfg_reg.start_charge_mv  <= RST_START_CHARGE;
            cfg_reg.battery_off_mv   <= RST_BATTERY_OFF;
            cfg_reg.battery_low_mv   <= RST_BATTERY_LOW;
            cfg_reg.mains_return_mv  <= RST_MAINS_RETURN;
            cfg_reg.band_gap_mv      <= RST_BAND_GAP;
            cfg_reg.settle_load      <= RST_SETTLE_LOAD;
            cfg_reg.battery_disabled <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_STOP_CHARGE:    cfg_reg.stop_charge_mv   <= cfg_data;
                REG_START_CHARGE:   cfg_reg.start_charge_mv  <= cfg_data;
                REG_BATTERY_OFF:    cfg_reg.battery_off_mv   <= cfg_data;
                REG_BATTERY_LOW:    cfg_reg.battery_low_mv   <= cfg_data;
                REG_MAINS_RETURN:   cfg_reg.mains_return_mv  <= cfg_data;
                REG_BAND_GAP:       cfg_reg.band_gap_mv      <= cfg_data[11:0];
                REG_SETTLE_LOAD:    cfg_reg.settle_load      <= cfg_data;
                REG_BATTERY_DISABL: cfg_reg.battery_disabled <= cfg_data[0];
                default:            cfg_reg.battery_disabled <= cfg_reg.battery_disabled;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // a word in evaluation always produces a result on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after evaluation");

    // a held input word is never dropped while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input word lost under stall");

    // switch back to mains always reports the returned level and cancels shutdown
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.switch_pulse |->
            out_data_reg.battery_level == LVL_MAINS &&
            out_data_reg.shutdown_action == SHUT_CANCEL)
        else $error("switch request without mains level");

    // charger only runs while on mains
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.charger_on |->
            !out_data_reg.battery_led && out_data_reg.battery_enable)
        else $error("charge enabled while on battery");

endmodule

`default_nettype wire

// ----- rtl/bms_core.sv -----
`default_nettype none

module bms_core (
    input  var bms_pkg::cfg_t      cfg,
    input  var bms_pkg::state_t    state,
    input  var bms_pkg::in_word_t  word,
    output bms_pkg::state_t        state_next,
    output bms_pkg::out_word_t     result
);
    import bms_pkg::*;

    logic [15:0] count;
    logic [16:0] off_gap;
    logic [16:0] low_gap;
    logic [2:0]  lvl;
    logic [2:0]  lvl_before;
    logic        chg;

    assign off_gap = {1'b0, cfg.battery_off_mv} + {5'd0, cfg.band_gap_mv};
    assign low_gap = {1'b0, cfg.battery_low_mv} + {5'd0, cfg.band_gap_mv};

    always_comb begin
        count      = state.settle_count;
        lvl        = state.level_now;
        lvl_before = state.level_before;
        chg        = state.charging;
        result     = '0;
        result.battery_enable = 1'b1;

        if (word.settle_tick && count != 16'd0) begin
            count = count - 16'd1;
        end

        if (cfg.battery_disabled) begin
            result.battery_enable = 1'b0;
        end else if (word.on_mains) begin
            if (lvl != LVL_NONE) begin
                lvl                = LVL_NONE;
                lvl_before         = LVL_NONE;
                result.beep_select = BEEP_OFF;
                result.notify_code = NOTIFY_STATUS;
            end
            result.shutdown_action = SHUT_CANCEL;
            count = cfg.settle_load;
            if (word.vbat_mv > cfg.stop_charge_mv) begin
                chg = 1'b0;
            end
            if (word.vbat_mv < cfg.start_charge_mv) begin
                chg = 1'b1;
            end
            result.charger_on = chg;
        end else begin
            chg                = 1'b0;
            result.battery_led = 1'b1;
            // later bands win, as in the threshold order
            if (word.vbat_mv < cfg.battery_off_mv) begin
                lvl = LVL_CRITICAL;
            end
            if ({1'b0, word.vbat_mv} > off_gap && word.vbat_mv < cfg.battery_low_mv) begin
                lvl = LVL_LOW;
            end
            if ({1'b0, word.vbat_mv} > low_gap) begin
                lvl = LVL_GOOD;
            end
            if (lvl != lvl_before) begin
                priority if (lvl == LVL_CRITICAL) begin
                    result.notify_code     = NOTIFY_EMERGENCY;
                    result.beep_select     = BEEP_EXTRA;
                    result.shutdown_action = SHUT_ARM;
                end else if (lvl == LVL_LOW) begin
                    result.notify_code     = NOTIFY_STATUS;
                    result.beep_select     = BEEP_SHORT;
                    result.shutdown_action = SHUT_CANCEL;
                end else if (lvl == LVL_GOOD) begin
                    result.notify_code     = NOTIFY_STATUS;
                    result.beep_select     = BEEP_LONG;
                    result.shutdown_action = SHUT_CANCEL;
                end else begin
                    result.notify_code = NOTIFY_NONE;
                end
            end
            lvl_before = lvl;
            if (count == 16'd0 && word.vin_mv > cfg.mains_return_mv) begin
                result.switch_pulse    = 1'b1;
                result.shutdown_action = SHUT_CANCEL;
                result.beep_select     = BEEP_OFF;
                lvl                    = LVL_MAINS;
                lvl_before             = LVL_NONE;
            end
        end

        result.battery_level    = lvl;
        state_next.level_now    = lvl;
        state_next.level_before = lvl_before;
        state_next.charging     = chg;
        state_next.settle_count = count;
    end

endmodule

`default_nettype wire

// ----- test/battery_mains_supervisor_checker.sv -----
`default_nettype none

module battery_mains_supervisor_checker (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  var bms_pkg::in_word_t              s_data,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  var bms_pkg::out_word_t             m_data,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready,
    input  wire [bms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [bms_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                 fail_count,
    output int                                 pending
);

    import bms_pkg::*;

    cfg_t      regs;
    state_t    st;
    out_word_t expected_words[$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic out_word_t supervise(input in_word_t w);
        out_word_t   r;
        logic [16:0] off_top;
        logic [16:0] low_top;
        r = '0;
        r.battery_enable = 1'b1;
        off_top = {1'b0, regs.battery_off_mv} + {5'b0, regs.band_gap_mv};
        low_top = {1'b0, regs.battery_low_mv} + {5'b0, regs.band_gap_mv};
        if (w.settle_tick && st.settle_count != 16'd0) begin
            st.settle_count = st.settle_count - 16'd1;
        end
        if (regs.battery_disabled) begin
            r.battery_enable = 1'b0;
        end else if (w.on_mains) begin
            if (st.level_now != LVL_NONE) begin
                st.level_now = LVL_NONE;
                st.level_before = LVL_NONE;
                r.beep_select = BEEP_OFF;
                r.notify_code = NOTIFY_STATUS;
            end
            r.shutdown_action = SHUT_CANCEL;
            st.settle_count = regs.settle_load;
            if (w.vbat_mv > regs.stop_charge_mv) begin
                st.charging = 1'b0;
            end
            if (w.vbat_mv < regs.start_charge_mv) begin
                st.charging = 1'b1;
            end
            r.charger_on = st.charging;
        end else begin
            st.charging = 1'b0;
            r.battery_led = 1'b1;
            if (w.vbat_mv < regs.battery_off_mv) begin
                st.level_now = LVL_CRITICAL;
            end
            if ({1'b0, w.vbat_mv} > off_top && w.vbat_mv < regs.battery_low_mv) begin
                st.level_now = LVL_LOW;
            end
            if ({1'b0, w.vbat_mv} > low_top) begin
                st.level_now = LVL_GOOD;
            end
            if (st.level_now != st.level_before) begin
                case (st.level_now)
                    LVL_CRITICAL: begin
                        r.notify_code = NOTIFY_EMERGENCY;
                        r.beep_select = BEEP_EXTRA;
                        r.shutdown_action = SHUT_ARM;
                    end
                    LVL_LOW: begin
                        r.notify_code = NOTIFY_STATUS;
                        r.beep_select = BEEP_SHORT;
                        r.shutdown_action = SHUT_CANCEL;
                    end
                    LVL_GOOD: begin
                        r.notify_code = NOTIFY_STATUS;
                        r.beep_select = BEEP_LONG;
                        r.shutdown_action = SHUT_CANCEL;
                    end
                    default: ;
                endcase
            end
            st.level_before = st.level_now;
            // settled and mains is back: ask for the transfer
            if (st.settle_count == 16'd0 && w.vin_mv > regs.mains_return_mv) begin
                r.switch_pulse = 1'b1;
                r.shutdown_action = SHUT_CANCEL;
                st.level_now = LVL_MAINS;
                st.level_before = LVL_NONE;
                r.beep_select = BEEP_OFF;
            end
        end
        r.battery_level = st.level_now;
        return r;
    endfunction

    function automatic string field_diff(input out_word_t e, input out_word_t a);
        string s;
        s = "";
        if (a.battery_enable !== e.battery_enable) s = {s, " battery_enable"};
        if (a.charger_on !== e.charger_on) s = {s, " charger_on"};
        if (a.battery_led !== e.battery_led) s = {s, " battery_led"};
        if (a.battery_level !== e.battery_level) s = {s, " battery_level"};
        if (a.notify_code !== e.notify_code) s = {s, " notify_code"};
        if (a.beep_select !== e.beep_select) s = {s, " beep_select"};
        if (a.shutdown_action !== e.shutdown_action) s = {s, " shutdown_action"};
        if (a.switch_pulse !== e.switch_pulse) s = {s, " switch_pulse"};
        return s;
    endfunction

    task automatic note_failure(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        out_word_t e;
        string     bad;
        if (!aresetn) begin
            regs.stop_charge_mv = RST_STOP_CHARGE;
            regs.start_charge_mv = RST_START_CHARGE;
            regs.battery_off_mv = RST_BATTERY_OFF;
            regs.battery_low_mv = RST_BATTERY_LOW;
            regs.mains_return_mv = RST_MAINS_RETURN;
            regs.band_gap_mv = RST_BAND_GAP;
            regs.settle_load = RST_SETTLE_LOAD;
            regs.battery_disabled = 1'b0;
            st = '0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("result word %h with none expected", m_data));
                end else begin
                    e = expected_words.pop_front();
                    bad = field_diff(e, m_data);
                    if (bad != "") begin
                        note_failure($sformatf("result word expected %h actual %h, wrong:%s",
                                               e, m_data, bad));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_STOP_CHARGE:    regs.stop_charge_mv = cfg_data;
                    REG_START_CHARGE:   regs.start_charge_mv = cfg_data;
                    REG_BATTERY_OFF:    regs.battery_off_mv = cfg_data;
                    REG_BATTERY_LOW:    regs.battery_low_mv = cfg_data;
                    REG_MAINS_RETURN:   regs.mains_return_mv = cfg_data;
                    REG_BAND_GAP:       regs.band_gap_mv = cfg_data[11:0];
                    REG_SETTLE_LOAD:    regs.settle_load = cfg_data;
                    REG_BATTERY_DISABL: regs.battery_disabled = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(supervise(s_data));
            end
        end
        pending = expected_words.size();
    end

endmodule

`default_nettype wire

// ----- test/tb_battery_mains_supervisor.sv -----
`default_nettype none

module tb_battery_mains_supervisor;

    import bms_pkg::*;

    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 300000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   fail_count;
    int   pending;
    bit   calm = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   on_mains_now = 1'b0;
    int   run_left = 0;
    cfg_t regs_now;

    battery_mains_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    battery_mains_supervisor_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: short random stalls, one long hold on request
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    function automatic cfg_t settings(input logic [15:0] stop, input logic [15:0] start,
                                      input logic [15:0] off, input logic [15:0] low,
                                      input logic [15:0] ret, input logic [11:0] gap,
                                      input logic [15:0] load, input logic dis);
        cfg_t c;
        c.stop_charge_mv = stop;
        c.start_charge_mv = start;
        c.battery_off_mv = off;
        c.battery_low_mv = low;
        c.mains_return_mv = ret;
        c.band_gap_mv = gap;
        c.settle_load = load;
        c.battery_disabled = dis;
        return c;
    endfunction

    function automatic logic [15:0] near(input int base);
        int v;
        v = base + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic push_word(input in_word_t w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic measure(input logic [15:0] vin, input logic [15:0] vbat,
                           input logic mains, input logic tick);
        in_word_t w;
        w.vin_mv = vin;
        w.vbat_mv = vbat;
        w.on_mains = mains;
        w.settle_tick = tick;
        push_word(w);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_settings(input cfg_t c);
        drain();
        write_reg(REG_STOP_CHARGE, c.stop_charge_mv);
        write_reg(REG_START_CHARGE, c.start_charge_mv);
        write_reg(REG_BATTERY_OFF, c.battery_off_mv);
        write_reg(REG_BATTERY_LOW, c.battery_low_mv);
        write_reg(REG_MAINS_RETURN, c.mains_return_mv);
        write_reg(REG_BAND_GAP, {4'b0, c.band_gap_mv});
        write_reg(REG_SETTLE_LOAD, c.settle_load);
        write_reg(REG_BATTERY_DISABL, {15'b0, c.battery_disabled});
        regs_now = c;
    endtask

    // mains and battery runs with voltages clustered on the thresholds
    task automatic random_words(input int count);
        in_word_t w;
        int       pick;
        repeat (count) begin
            if (run_left == 0) begin
                on_mains_now = !on_mains_now;
                run_left = on_mains_now ? $urandom_range(1, 6) : $urandom_range(1, 20);
            end
            run_left = run_left - 1;
            pick = $urandom_range(0, 9);
            case (pick)
                2: w.vbat_mv = near(int'(regs_now.stop_charge_mv));
                3: w.vbat_mv = near(int'(regs_now.start_charge_mv));
                4: w.vbat_mv = near(int'(regs_now.battery_off_mv));
                5: w.vbat_mv = near(int'(regs_now.battery_off_mv) + int'(regs_now.band_gap_mv));
                6: w.vbat_mv = near(int'(regs_now.battery_low_mv));
                7: w.vbat_mv = near(int'(regs_now.battery_low_mv) + int'(regs_now.band_gap_mv));
                default: w.vbat_mv = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 2))
                0: w.vin_mv = 16'($urandom_range(0, 65535));
                1: w.vin_mv = near(int'(regs_now.mains_return_mv));
                default: w.vin_mv = 16'($urandom_range(0, 3000));
            endcase
            w.on_mains = on_mains_now ^ ($urandom_range(0, 19) == 0);
            w.settle_tick = ($urandom_range(0, 9) < 7);
            push_word(w);
        end
    endtask

    initial begin
        cfg_t c;
        regs_now = settings(RST_STOP_CHARGE, RST_START_CHARGE, RST_BATTERY_OFF,
                            RST_BATTERY_LOW, RST_MAINS_RETURN, RST_BAND_GAP,
                            RST_SETTLE_LOAD, 1'b0);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // settle counter starts at zero: switch at once, tick held at zero
        measure(16'd65535, 16'd3450, 1'b0, 1'b1);
        // returned to mains level with no band hit: nothing announced
        measure(16'd0, 16'd3450, 1'b0, 1'b0);
        measure(16'd0, 16'd0, 1'b0, 1'b1);
        measure(16'd0, 16'd3300, 1'b0, 1'b0);
        measure(16'd0, 16'd3501, 1'b0, 1'b0);
        measure(16'd0, 16'd3600, 1'b0, 1'b0);
        measure(16'd0, 16'd3801, 1'b0, 1'b0);
        measure(16'd0, 16'd65535, 1'b0, 1'b1);
        measure(16'd10000, 16'd2000, 1'b0, 1'b0);
        // band change and switch in the same word
        measure(16'd10001, 16'd3801, 1'b0, 1'b0);
        measure(16'd0, 16'd3899, 1'b1, 1'b1);
        measure(16'd0, 16'd3900, 1'b1, 1'b0);
        measure(16'd0, 16'd4150, 1'b1, 1'b1);
        measure(16'd0, 16'd4151, 1'b1, 1'b0);
        measure(16'd0, 16'd65535, 1'b1, 1'b0);
        measure(16'd0, 16'd0, 1'b1, 1'b1);
        measure(16'd65535, 16'd65535, 1'b0, 1'b1);
        measure(16'd65535, 16'd0, 1'b0, 1'b1);
        random_words(200);

        load_settings(settings(16'd4150, 16'd3900, 16'd3300, 16'd3600, 16'd10000,
                               12'd200, 16'd4, 1'b0));
        long_hold_req = 1'b1;
        random_words(300);

        load_settings(settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 16'd0, 1'b0));
        measure(16'd0, 16'd0, 1'b1, 1'b1);
        measure(16'd1, 16'd0, 1'b0, 1'b0);
        measure(16'd0, 16'd1, 1'b0, 1'b1);
        random_words(150);

        load_settings(settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               12'hFFF, 16'hFFFF, 1'b0));
        measure(16'd65535, 16'd65535, 1'b0, 1'b1);
        measure(16'd65535, 16'd65534, 1'b1, 1'b0);
        random_words(150);

        load_settings(settings(16'd4150, 16'd3900, 16'd3300, 16'd3600, 16'd10000,
                               12'd200, 16'd2, 1'b1));
        measure(16'd65535, 16'd0, 1'b1, 1'b1);
        measure(16'd65535, 16'd0, 1'b0, 1'b1);
        random_words(150);

        repeat (3) begin
            c = settings(16'($urandom_range(3000, 5000)), 16'($urandom_range(3000, 5000)),
                         16'($urandom_range(2500, 3800)), 16'($urandom_range(2500, 4200)),
                         16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                         16'($urandom_range(0, 12)), ($urandom_range(0, 7) == 0));
            load_settings(c);
            random_words(150);
        end

        load_settings(settings(16'd4150, 16'd3900, 16'd3300, 16'd3600, 16'd10000,
                               12'd200, 16'd3, 1'b0));
        calm = 1'b1;
        random_words(150);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/bms_pkg.sv
rtl/bms_core.sv
rtl/battery_mains_supervisor.sv
test/battery_mains_supervisor_checker.sv
test/tb_battery_mains_supervisor.sv
